// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: capacity, entry and control types,
// operation and status codes. Depends on nothing; every RTL file imports it.
`default_nettype none

package spq_pkg;

  // Number of cells in the chain (2 to 31, so that the count fits the OCC_W-bit occupancy field).
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int PAYLOAD_W = 32;
  localparam int PRIO_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // Request and result bus widths, padded to whole bytes.
  localparam int IN_W  = 56;
  localparam int OUT_W = 56;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Contents of one cell.
  typedef struct packed {
    logic                     valid;
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Chain-wide command for the current cycle.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] prio;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and moves it to a neighbor
// on insert or remove. Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       left_keep,  // left neighbor keeps its entry on insert
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  output logic            keep,       // this entry sorts ahead of the new key
  output entry_t          entry
);

  entry_t entry_next;

  // A stored entry stays in place when the new key is strictly greater.
  assign keep = entry.valid && (ctrl.prio > entry.prio);

  // Insert: keep, take the new entry at the boundary, or shift right.
  // Remove: take the right neighbor's entry.
  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next.valid   = 1'b1;
        entry_next.payload = ctrl.payload;
        entry_next.prio    = ctrl.prio;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.del) begin
      entry_next = right_entry;
    end
  end

  // Only the valid bit is reset; payload and priority are don't-care until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.payload <= entry_next.payload;
    entry.prio    <= entry_next.prio;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: request decode, chain of cells,
// occupancy count and result register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Requests arrive on s_tvalid/s_tready/s_tdata. Each request is either an
//   enqueue (payload with signed priority) or a dequeue of the entry with the
//   smallest priority; among equal priorities the newest leaves first.
//   Every request gives exactly one result on m_tvalid/m_tready/m_tdata with
//   the removed payload and priority, a status code and the occupancy.
//   The result is registered in the cycle after acceptance. Throughput is one
//   request per cycle unless the receiver stalls: all cells compare against
//   the new key and shift in the same cycle, whatever the capacity.
//   The result register frees up when it is taken, so a new request is
//   accepted while m_tready is high or the result register is empty.
//   When the receiver stalls, the result holds and s_tready drops.
//   Synchronous reset empties the queue and drops any pending result; no
//   clearing pass is needed, only the valid bits of the cells are cleared.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // [0] operation, [32:1] payload, [48:33] priority_req, [55:49] zero
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [31:0] out_payload, [47:32] out_priority, [49:48] status,
  // [54:50] occupancy, [55] zero
  output logic [OUT_W-1:0]      m_tdata
);

  // Request fields.
  op_t                      req_op;
  logic [PAYLOAD_W-1:0]     req_payload;
  logic signed [PRIO_W-1:0] req_prio;

  assign req_op      = op_t'(s_tdata[0]);
  assign req_payload = s_tdata[PAYLOAD_W:1];
  assign req_prio    = s_tdata[PAYLOAD_W+PRIO_W:PAYLOAD_W+1];

  // Chain wiring.
  entry_t               cells [CAPACITY];
  logic [CAPACITY-1:0]  keeps;
  logic [CAPACITY-1:0]  vld;
  cell_ctrl_t           ctrl;

  logic                 accept;
  logic                 full;
  logic                 empty;

  // Registers.
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [PAYLOAD_W-1:0] res_payload;
  logic [PAYLOAD_W-1:0] res_payload_next;
  logic [PRIO_W-1:0]    res_prio;
  logic [PRIO_W-1:0]    res_prio_next;
  status_t              res_status;
  status_t              res_status_next;

  // Handshake and request decode.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = vld[CAPACITY-1];
  assign empty    = !vld[0];

  assign ctrl.ins     = accept && (req_op == OP_ENQUEUE) && !full;
  assign ctrl.del     = accept && (req_op == OP_DEQUEUE) && !empty;
  assign ctrl.payload = req_payload;
  assign ctrl.prio    = req_prio;

  // The chain of cells, head at index 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = cells[0];
    end else begin : g_body
      assign left_keep  = keeps[i-1];
      assign left_entry = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .keep        (keeps[i]),
      .entry       (cells[i])
    );

    assign vld[i] = cells[i].valid;
  end

  // Occupancy and result for the accepted request.
  always_comb begin
    count_next       = count;
    res_payload_next = res_payload;
    res_prio_next    = res_prio;
    res_status_next  = res_status;
    if (accept) begin
      res_payload_next = '0;
      res_prio_next    = '0;
      res_status_next  = ST_DONE;
      unique case (req_op)
        OP_ENQUEUE: begin
          if (full) begin
            res_status_next = ST_FULL;
          end else begin
            count_next = count + 1'b1;
          end
        end
        OP_DEQUEUE: begin
          if (empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            res_payload_next = cells[0].payload;
            res_prio_next    = cells[0].prio;
            count_next       = count - 1'b1;
          end
        end
        default: begin
          res_status_next = ST_DONE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload, priority and status registers.
  always_ff @(posedge clk) begin
    res_payload <= res_payload_next;
    res_prio    <= res_prio_next;
    res_status  <= res_status_next;
  end

  assign m_tdata = {1'b0, OCC_W'(count), res_status, res_prio, res_payload};

`ifndef SYNTH
  logic [CAPACITY-2:0] ordered;

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order
    assign ordered[j] = !cells[j+1].valid || (cells[j].prio <= cells[j+1].prio);
  end

  // Stored entries form a packed prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, vld} + 1'b1))
    else $error("cell valid bits are not a packed prefix");

  // The occupancy counter tracks the number of valid cells.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(vld)))
    else $error("occupancy counter disagrees with valid cells");

  // Valid entries stay sorted by ascending priority.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &ordered)
    else $error("chain is out of priority order");

  // A dequeue of a non-empty queue returns the previous head.
  a_head_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.del |=> (res_payload == $past(cells[0].payload))
                 && (res_status == ST_DONE))
    else $error("dequeue did not return the head entry");
`endif

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_test.sv =====
// Self-checking testbench for sorted_priority_queue: a directed table, then random
// enqueue/dequeue traffic, checked against a behavioral sorted list.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
`default_nettype none

module sorted_priority_queue_test;
  import spq_pkg::*;

  // Pacing of the two stream sides.
  typedef enum int {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct {
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] prio;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

  typedef struct {
    op_t                      op;
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] prio;
    bit                       fixed;
    result_t                  want;
  } row_t;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int DIRECTED_ROWS   = 24;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  pace_t   pace = PACE_FULL;
  int      error_count = 0;
  result_t pending_results[$];

  // Behavioral copy of the queue: a sorted prefix, head at index 0.
  logic [PAYLOAD_W-1:0]     held_payload [CAPACITY];
  logic signed [PRIO_W-1:0] held_prio [CAPACITY];
  int                       held_count = 0;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the sorted list and returns the result it gives.
  function automatic result_t queue_step(input op_t op, input logic [PAYLOAD_W-1:0] payload,
                                         input logic signed [PRIO_W-1:0] prio);
    result_t r;
    int      pos;
    r.payload = '0;
    r.prio    = '0;
    r.status  = ST_DONE;
    if (op == OP_ENQUEUE) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes ahead of every entry with an equal or larger key.
        pos = 0;
        while (pos < held_count && prio > held_prio[pos]) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_payload[i] = held_payload[i-1];
          held_prio[i]    = held_prio[i-1];
        end
        held_payload[pos] = payload;
        held_prio[pos]    = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.payload = held_payload[0];
        r.prio    = held_prio[0];
        for (int i = 0; i + 1 < held_count; i++) begin
          held_payload[i] = held_payload[i+1];
          held_prio[i]    = held_prio[i+1];
        end
        held_count--;
      end
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  function automatic bit sender_idles();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(99) < 72;
      PACE_BOTH:      return $urandom_range(99) < 9;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(99) < 72;
      PACE_BOTH:        return $urandom_range(99) < 9;
      default:          return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Drives one request from a falling edge and returns at the falling edge after
  // it is accepted. The expected result is queued at the accepting edge.
  task automatic send_request(input op_t op, input logic [PAYLOAD_W-1:0] payload,
                              input logic signed [PRIO_W-1:0] prio, input bit fixed,
                              input result_t want);
    result_t predicted;
    while (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, prio, payload, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = queue_step(op, payload, prio);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // The receiver stalls according to the current pacing.
  always @(negedge clk) begin
    m_tready <= !receiver_stalls();
  end

  // Compares every accepted result with the oldest expected one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.payload)
          report_mismatch("out_payload", m_tdata[31:0], want.payload);
        if (m_tdata[47:32] !== want.prio)
          report_mismatch("out_priority", 32'(m_tdata[47:32]), 32'(want.prio));
        if (m_tdata[49:48] !== want.status)
          report_mismatch("status", 32'(m_tdata[49:48]), 32'(want.status));
        if (m_tdata[54:50] !== want.occupancy)
          report_mismatch("occupancy", 32'(m_tdata[54:50]), 32'(want.occupancy));
      end
    end
  end

  // Stimulus: directed rows first, then random traffic in pacing phases.
  initial begin
    row_t    rows [DIRECTED_ROWS];
    result_t none;
    op_t     op;
    int      enqueue_bias;
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] prio;

    none = '{payload: '0, prio: '0, status: ST_DONE, occupancy: '0};
    // Rows with fixed set carry a hand-written result; the rest use the predictor.
    // The fill rows take the queue from two entries to exactly CAPACITY (16).
    rows = '{
      // Dequeue on an empty queue right after reset.
      '{OP_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b1, '{'0, '0, ST_EMPTY, 5'd0}},
      // Extremes of payload and priority.
      '{OP_ENQUEUE, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1, '{'0, '0, ST_DONE, 5'd1}},
      '{OP_ENQUEUE, 32'h0000_0000, 16'sh8000, 1'b0, none},
      // Equal priorities: the newer entry must leave first.
      '{OP_ENQUEUE, 32'h1234_5678, 16'sh0000, 1'b0, none},
      '{OP_ENQUEUE, 32'hA5A5_A5A5, 16'sh0000, 1'b0, none},
      '{OP_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b0, none},
      '{OP_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b0, none},
      // Fill up to capacity.
      '{OP_ENQUEUE, 32'h0000_0001, 16'shFFFF, 1'b0, none},
      '{OP_ENQUEUE, 32'h0000_0002, 16'sh0001, 1'b0, none},
      '{OP_ENQUEUE, 32'h0000_0003, 16'sh7FFF, 1'b0, none},
      '{OP_ENQUEUE, 32'h0000_0004, 16'sh8000, 1'b0, none},
      '{OP_ENQUEUE, 32'h5555_5555, 16'sh5555, 1'b0, none},
      '{OP_ENQUEUE, 32'hAAAA_AAAA, 16'shAAAA, 1'b0, none},
      '{OP_ENQUEUE, 32'h8000_0000, 16'sh8001, 1'b0, none},
      '{OP_ENQUEUE, 32'h7FFF_FFFF, 16'sh7FFE, 1'b0, none},
      '{OP_ENQUEUE, 32'hDEAD_BEEF, 16'sh0000, 1'b0, none},
      '{OP_ENQUEUE, 32'h0F0F_0F0F, 16'shFFFF, 1'b0, none},
      '{OP_ENQUEUE, 32'hF0F0_F0F0, 16'sh0100, 1'b0, none},
      '{OP_ENQUEUE, 32'h0000_00FF, 16'shFF00, 1'b0, none},
      '{OP_ENQUEUE, 32'h00FF_0000, 16'sh0010, 1'b0, none},
      '{OP_ENQUEUE, 32'hCAFE_F00D, 16'sh0001, 1'b0, none},
      // Enqueue into a full queue is rejected.
      '{OP_ENQUEUE, 32'h1111_1111, 16'sh0000, 1'b1,
        '{'0, '0, ST_FULL, 5'(CAPACITY)}},
      // Dequeue with payload and priority set, which must be ignored.
      '{OP_DEQUEUE, 32'hFFFF_FFFF, 16'shFFFF, 1'b0, none},
      // Largest key again, landing ahead of the stored entries with the same key.
      '{OP_ENQUEUE, 32'h2222_2222, 16'sh7FFF, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].op, rows[i].payload, rows[i].prio,
                                   rows[i].fixed, rows[i].want);

    enqueue_bias = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pace = pace_t'((i / 125) % 4);
      // Shift the mix now and then so the queue swings between full and empty.
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       enqueue_bias = 15;
          1:       enqueue_bias = 50;
          default: enqueue_bias = 85;
        endcase
      end
      op      = ($urandom_range(99) < enqueue_bias) ? OP_ENQUEUE : OP_DEQUEUE;
      payload = $urandom;
      // A narrow key range now and then makes ties common.
      if ($urandom_range(3) == 0) prio = PRIO_W'($signed($urandom_range(8)) - 4);
      else prio = PRIO_W'($urandom);
      send_request(op, payload, prio, 1'b0, none);
    end
    s_tvalid <= 1'b0;
    pace = PACE_FULL;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
